>>> rtl/assert_macros.svh
// Assertion helper macros for the length-framed receive classifier.
// Included by RTL modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define LFRC_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LFRC_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lfrc_pkg.sv
// Shared types, constants and the prefix table of the receive classifier.
// No dependencies; imported by lfrc_prefix_cmp and length_framed_rx_classifier_core.
package lfrc_pkg;

  localparam int FRAME_DEPTH_DEF = 64;
  localparam int MAX_OUT         = 64;
  localparam int N_TYPES         = 18;
  localparam int HEAD_BYTES      = 5;

  localparam logic [6:0] LIMIT_RESET = 7'd50;
  localparam logic [6:0] REPAIR_LEN  = 7'd7;

  localparam logic [7:0] SIG_B0 = 8'h07;
  localparam logic [7:0] SIG_B1 = 8'h20;
  localparam logic [7:0] SIG_B2 = 8'h90;
  localparam logic [7:0] SIG_B3 = 8'h00;
  localparam logic [4:0] LEN_HI_MASK = 5'h1F;

  localparam logic [4:0] TYPE_LAST = 5'(N_TYPES - 1);

  typedef logic [HEAD_BYTES-1:0][7:0] head_t;

  typedef struct packed {
    logic [HEAD_BYTES-1:0] mask;  // positions that take part in the compare
    head_t                 bytes; // expected byte at each position
  } prefix_t;

  typedef enum logic [2:0] {
    ST_HDR0,
    ST_HDR1,
    ST_BODY,
    ST_HUNT,
    ST_CLS,
    ST_RD,
    ST_SEND
  } state_t;

  function automatic prefix_t mk_prefix(input logic [HEAD_BYTES-1:0] mask,
                                        input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [7:0] b4);
    prefix_t p;
    p.mask     = mask;
    p.bytes[0] = b0;
    p.bytes[1] = b1;
    p.bytes[2] = b2;
    p.bytes[3] = b3;
    p.bytes[4] = b4;
    return p;
  endfunction

  // Message prefixes in classification order
  function automatic prefix_t prefix_entry(input logic [4:0] t);
    prefix_t p;
    case (t)
      5'd0:    p = mk_prefix(5'b01111, 8'h07, 8'h20, 8'h90, 8'h00, 8'h00);
      5'd1:    p = mk_prefix(5'b00011, 8'h12, 8'hC0, 8'h00, 8'h00, 8'h00);
      5'd2:    p = mk_prefix(5'b00011, 8'h2F, 8'hA0, 8'h00, 8'h00, 8'h00);
      5'd3:    p = mk_prefix(5'b00011, 8'h2F, 8'h60, 8'h00, 8'h00, 8'h00);
      5'd4:    p = mk_prefix(5'b01111, 8'h05, 8'h20, 8'h18, 8'h01, 8'h00);
      5'd5:    p = mk_prefix(5'b00111, 8'h03, 8'h60, 8'h00, 8'h00, 8'h00);
      5'd6:    p = mk_prefix(5'b00011, 8'h42, 8'h81, 8'h00, 8'h00, 8'h00);
      5'd7:    p = mk_prefix(5'b11111, 8'h05, 8'h00, 8'h18, 8'h00, 8'h01);
      5'd8:    p = mk_prefix(5'b11111, 8'h05, 8'h00, 8'h18, 8'h00, 8'h00);
      5'd9:    p = mk_prefix(5'b01111, 8'h10, 8'h00, 8'h01, 8'h00, 8'h00);
      5'd10:   p = mk_prefix(5'b01110, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00); // byte 0 free
      5'd11:   p = mk_prefix(5'b11111, 8'h07, 8'h00, 8'h04, 8'h00, 8'h01);
      5'd12:   p = mk_prefix(5'b01111, 8'h08, 8'h00, 8'h20, 8'h02, 8'h00);
      5'd13:   p = mk_prefix(5'b01111, 8'h0C, 8'h00, 8'h30, 8'h02, 8'h00);
      5'd14:   p = mk_prefix(5'b11111, 8'h05, 8'h00, 8'h28, 8'h00, 8'h01);
      5'd15:   p = mk_prefix(5'b11111, 8'h05, 8'h00, 8'h2A, 8'h00, 8'h00);
      5'd16:   p = mk_prefix(5'b01111, 8'h06, 8'h00, 8'h38, 8'h01, 8'h00);
      5'd17:   p = mk_prefix(5'b01111, 8'h05, 8'h00, 8'h80, 8'h00, 8'h00);
      default: p = mk_prefix(5'b00000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endcase
    return p;
  endfunction

endpackage

>>> rtl/lfrc_prefix_cmp.sv
// Prefix compare unit: tests the frame head against one table entry per cycle.
// Depends on lfrc_pkg (prefix table, head_t).
module lfrc_prefix_cmp
  import lfrc_pkg::*;
(
  input  logic [4:0] type_idx,
  input  head_t      head,
  input  logic [6:0] frame_len,
  output logic       match
);

  prefix_t entry;
  logic [HEAD_BYTES-1:0] pos_ok;

  assign entry = prefix_entry(type_idx);

  // a masked position at or past the frame length never matches
  always_comb begin
    for (int p = 0; p < HEAD_BYTES; p++) begin
      pos_ok[p] = !entry.mask[p] ||
                  ((7'(p) < frame_len) && (head[p] == entry.bytes[p]));
    end
  end

  assign match = &pos_ok;

endmodule

>>> rtl/length_framed_rx_classifier_core.sv
// Receive classifier: one byte transaction per cycle while receiving; after the last byte
// of a frame the prefix search walks the table (one table entry per cycle), then each
// replayed byte passes a store read, then the output register, when the sink is ready.
// Reset (rst_n, synchronous, active low) clears control, limit (50) and hunt window;
// the frame store is not cleared and needs no clearing pass.
module length_framed_rx_classifier_core
  import lfrc_pkg::*;
#(
  parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  // received bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // replayed frame bytes
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_frame_type,
  output logic [6:0] out_frame_length,
  output logic [5:0] out_byte_index,
  output logic [7:0] out_byte_value,
  output logic       out_last_byte
);

`include "assert_macros.svh"

  localparam int AW  = $clog2(FRAME_DEPTH);
  // largest length ever accepted: bounded by the store and by one replay
  localparam int CAP = (FRAME_DEPTH < MAX_OUT) ? FRAME_DEPTH : MAX_OUT;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t     state_r, state_nxt;
  logic [6:0] limit_r;
  logic [6:0] byte_count_r, byte_count_nxt;
  logic [6:0] dl_r, dl_nxt;           // decoded length of the current frame
  logic [4:0] type_r, type_nxt;       // classifier sequencer / matched type
  logic [5:0] idx_r, idx_nxt;         // replay position
  head_t      head_r, head_nxt;       // first bytes, kept for the compare unit
  logic [7:0] hunt_w_r [7];
  logic [7:0] hunt_w_nxt [7];

  logic       out_valid_r, out_valid_nxt;
  logic [4:0] out_type_r;
  logic [6:0] out_len_r;
  logic [5:0] out_idx_r;
  logic [7:0] out_val_r;
  logic       out_last_r;

  // frame store, single write port, registered read
  logic [7:0]    mem [FRAME_DEPTH];
  logic [7:0]    mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic        in_fire;
  logic [6:0]  eff_lim;
  logic        repair;
  logic [12:0] hdr_len;
  logic [6:0]  hdr_cnt;
  logic        hdr_over;
  logic        hdr_done;
  logic [6:0]  cnt_inc;
  logic        body_done;
  logic        sig_hit;
  logic        cls_match;
  logic        out_load;
  logic        last_now;
  logic [7:0]  byte_sel;

  assign in_fire = in_valid && in_ready;
  assign eff_lim = (limit_r > 7'(CAP)) ? 7'(CAP) : limit_r;

  // a frame opening 20 90 lost its first byte: rebuild it as 07 20 90, length 7
  assign repair   = (head_r[0] == SIG_B1) && (in_rx_byte == SIG_B2);
  assign hdr_len  = repair ? 13'(REPAIR_LEN) : {in_rx_byte[4:0] & LEN_HI_MASK, head_r[0]};
  assign hdr_cnt  = repair ? 7'd3 : 7'd2;
  assign hdr_over = hdr_len > 13'(eff_lim);
  assign hdr_done = hdr_cnt >= hdr_len[6:0];

  assign cnt_inc   = byte_count_r + 7'd1;
  assign body_done = cnt_inc >= dl_r;

  // signature checked at the head of the window after this byte shifts in
  assign sig_hit = (hunt_w_r[1] == SIG_B0) && (hunt_w_r[2] == SIG_B1) &&
                   (hunt_w_r[3] == SIG_B2) && (hunt_w_r[4] == SIG_B3);

  assign out_load = (state_r == ST_SEND) && (!out_valid_r || out_ready);
  assign last_now = ({1'b0, idx_r} + 7'd1) == dl_r;

  lfrc_prefix_cmp u_cmp (
    .type_idx  (type_r),
    .head      (head_r),
    .frame_len (dl_r),
    .match     (cls_match)
  );

  // head bytes come from registers, the rest from the store
  always_comb begin
    case (idx_r)
      6'd0:    byte_sel = head_r[0];
      6'd1:    byte_sel = head_r[1];
      6'd2:    byte_sel = head_r[2];
      6'd3:    byte_sel = head_r[3];
      6'd4:    byte_sel = head_r[4];
      default: byte_sel = mem_q_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HDR0: begin
        if (in_fire) state_nxt = ST_HDR1;
      end
      ST_HDR1: begin
        if (in_fire) begin
          if (hdr_over)      state_nxt = ST_HUNT;
          else if (hdr_done) state_nxt = ST_CLS;
          else               state_nxt = ST_BODY;
        end
      end
      ST_BODY: begin
        if (in_fire && body_done) state_nxt = ST_CLS;
      end
      ST_HUNT: begin
        if (in_fire && sig_hit) state_nxt = ST_HDR0;
      end
      ST_CLS: begin
        if (cls_match)                state_nxt = ST_RD;
        else if (type_r == TYPE_LAST) state_nxt = ST_HUNT;
      end
      ST_RD: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_load) state_nxt = last_now ? ST_HDR0 : ST_RD;
      end
      default: state_nxt = ST_HDR0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and handshake outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready       = 1'b0;
    byte_count_nxt = byte_count_r;
    dl_nxt         = dl_r;
    type_nxt       = type_r;
    idx_nxt        = idx_r;
    head_nxt       = head_r;
    hunt_w_nxt     = hunt_w_r;
    mem_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    case (state_r)
      ST_HDR0: begin
        in_ready = 1'b1;
        if (in_fire) begin
          head_nxt[0]    = in_rx_byte;
          byte_count_nxt = 7'd1;
        end
      end
      ST_HDR1: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (repair) begin
            head_nxt[0] = SIG_B0;
            head_nxt[1] = SIG_B1;
            head_nxt[2] = SIG_B2;
          end else begin
            head_nxt[1] = in_rx_byte;
          end
          byte_count_nxt = hdr_cnt;
          type_nxt       = '0;
          if (hdr_over) begin
            byte_count_nxt = '0;
            for (int k = 0; k < 7; k++) hunt_w_nxt[k] = '0;
          end else begin
            dl_nxt = hdr_len[6:0];
          end
        end
      end
      ST_BODY: begin
        in_ready = 1'b1;
        if (in_fire) begin
          mem_we = 9'(byte_count_r) < 9'(FRAME_DEPTH);
          if (byte_count_r < 7'(HEAD_BYTES)) head_nxt[byte_count_r[2:0]] = in_rx_byte;
          byte_count_nxt = cnt_inc;
          type_nxt       = '0;
        end
      end
      ST_HUNT: begin
        in_ready = 1'b1;
        if (in_fire) begin
          for (int k = 0; k < 6; k++) hunt_w_nxt[k] = hunt_w_r[k+1];
          hunt_w_nxt[6] = in_rx_byte;
          if (sig_hit) byte_count_nxt = '0;
        end
      end
      ST_CLS: begin
        if (cls_match) begin
          idx_nxt = '0;
        end else if (type_r == TYPE_LAST) begin
          byte_count_nxt = '0;
          for (int k = 0; k < 7; k++) hunt_w_nxt[k] = '0;
        end else begin
          type_nxt = type_r + 5'd1;
        end
      end
      ST_RD: begin
        // store read of idx_r lands in mem_q_r
      end
      ST_SEND: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (last_now) byte_count_nxt = '0;
          else          idx_nxt = idx_r + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_waddr = AW'(byte_count_r);
  assign mem_raddr = AW'(idx_r);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HDR0;
      limit_r      <= LIMIT_RESET;
      byte_count_r <= '0;
      dl_r         <= '0;
      type_r       <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 7; k++) hunt_w_r[k] <= '0;
    end else begin
      state_r      <= state_nxt;
      byte_count_r <= byte_count_nxt;
      dl_r         <= dl_nxt;
      type_r       <= type_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
      hunt_w_r     <= hunt_w_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (out_load) begin
      out_type_r <= type_r;
      out_len_r  <= dl_r;
      out_idx_r  <= idx_r;
      out_val_r  <= byte_sel;
      out_last_r <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= in_rx_byte;
    mem_q_r <= mem[mem_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_frame_type   = out_type_r;
  assign out_frame_length = out_len_r;
  assign out_byte_index   = out_idx_r;
  assign out_byte_value   = out_val_r;
  assign out_last_byte    = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `LFRC_CHECK_NEXT(a_result_only_in_replay, (state_r != ST_SEND) && !out_valid_r, !out_valid_r, "result transaction raised outside replay")
  `LFRC_CHECK(a_last_mark, out_valid_r, out_last_r == (({1'b0, out_idx_r} + 7'd1) == out_len_r), "last mark disagrees with index and length")
  `LFRC_CHECK(a_index_in_frame, out_valid_r, {1'b0, out_idx_r} < out_len_r, "replayed index beyond frame length")
  `LFRC_CHECK(a_len_capped, (state_r == ST_CLS) || (state_r == ST_RD) || (state_r == ST_SEND), dl_r <= 7'(CAP), "accepted length above store capacity")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for length_framed_rx_classifier_core: framing, repair, prefix
// classification, hunting and replay. Needs lfrc_pkg, the core RTL, lfrc_prefix_cmp and assert_macros.svh.
// A directed frame table runs first, then random byte streams in four handshake phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfrc_pkg::*;

  // Message types in the order the classifier tries them; FT_NONE means no prefix matched
  typedef enum logic [4:0] {
    FT_STATUS, FT_VOICE, FT_HEADER, FT_HEADER_ACK, FT_PTT, FT_ACK, FT_FM, FT_START,
    FT_STOP, FT_NAME, FT_SERIAL, FT_FIRMWARE, FT_FREQ, FT_LIMITS, FT_MODULATION,
    FT_MODE, FT_POWER, FT_SQUELCH, FT_NONE
  } ft_t;

  // One replayed frame byte, as the result port shows it
  typedef struct packed {
    ft_t        ftype;
    logic [6:0] flen;
    logic [5:0] idx;
    logic [7:0] val;
    logic       last;
  } replay_t;

  // Directed row: up to eight fixed leading bytes, then n_fill random bytes.
  // Where has_exp is set, the row's outcome is typed in and cross-checked.
  typedef struct packed {
    logic [0:7][7:0] lead;
    logic [3:0]      n_lead;
    logic [6:0]      n_fill;
    logic            has_exp;
    ft_t             exp_type;
    logic [6:0]      exp_results;
  } dir_row_t;

  localparam int WATCHDOG_CYCLES = 1000;
  localparam int DRAIN_CYCLES    = 24;   // longest classify run plus margin
  localparam int TAIL_CYCLES     = 40;
  localparam int RAND_PER_PHASE  = 12;
  localparam int STORE_DEPTH     = 64;
  localparam int N_DIR           = 28;

  localparam logic [7:0]      LOST_B0     = 8'h20;  // header of a status frame that lost byte 0
  localparam logic [7:0]      LOST_B1     = 8'h90;
  localparam logic [7:0]      REPAIRED_B0 = 8'h07;
  localparam logic [0:3][7:0] STATUS_SIG  = 32'h0720_9000;

  // Prefix bytes per type, position 0 leftmost; mask marks the positions compared
  localparam logic [0:17][0:4][7:0] PFX_BYTES = {
    40'h07_20_90_00_00, 40'h12_C0_00_00_00, 40'h2F_A0_00_00_00, 40'h2F_60_00_00_00,
    40'h05_20_18_01_00, 40'h03_60_00_00_00, 40'h42_81_00_00_00, 40'h05_00_18_00_01,
    40'h05_00_18_00_00, 40'h10_00_01_00_00, 40'h00_00_02_00_00, 40'h07_00_04_00_01,
    40'h08_00_20_02_00, 40'h0C_00_30_02_00, 40'h05_00_28_00_01, 40'h05_00_2A_00_00,
    40'h06_00_38_01_00, 40'h05_00_80_00_00
  };
  localparam logic [0:17][0:4] PFX_MASK = {
    5'b11110, 5'b11000, 5'b11000, 5'b11000, 5'b11110, 5'b11100, 5'b11000, 5'b11111,
    5'b11111, 5'b11110, 5'b01110, 5'b11111, 5'b11110, 5'b11110, 5'b11111, 5'b11111,
    5'b11110, 5'b11110
  };

  // Directed frames, run at the reset limit of 50
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{64'h0720_9000_0000_0000, 4'd4, 7'd3,  1'b1, FT_STATUS,     7'd7},
    '{64'h2090_0000_0000_0000, 4'd3, 7'd3,  1'b1, FT_STATUS,     7'd7},   // lost byte 0
    '{64'h12C0_0000_0000_0000, 4'd2, 7'd16, 1'b1, FT_VOICE,      7'd18},
    '{64'h2FA0_0000_0000_0000, 4'd2, 7'd45, 1'b1, FT_HEADER,     7'd47},
    '{64'h2F60_0000_0000_0000, 4'd2, 7'd45, 1'b1, FT_HEADER_ACK, 7'd47},
    '{64'h0520_1801_FF00_0000, 4'd5, 7'd0,  1'b1, FT_PTT,        7'd5},
    '{64'h0360_0000_0000_0000, 4'd3, 7'd0,  1'b1, FT_ACK,        7'd3},
    '{64'h4281_0720_9000_0000, 4'd6, 7'd3,  1'b1, FT_NONE,       7'd0},   // fm: always too long
    '{64'h0500_1800_0100_0000, 4'd5, 7'd0,  1'b1, FT_START,      7'd5},
    '{64'h0500_1800_0000_0000, 4'd5, 7'd0,  1'b1, FT_STOP,       7'd5},
    '{64'h1000_0100_0000_0000, 4'd4, 7'd12, 1'b1, FT_NAME,       7'd16},
    '{64'h3200_0200_0000_0000, 4'd4, 7'd46, 1'b1, FT_SERIAL,     7'd50},  // right at the limit
    '{64'h0700_0400_0100_0000, 4'd5, 7'd2,  1'b1, FT_FIRMWARE,   7'd7},
    '{64'h0800_2002_0000_0000, 4'd4, 7'd4,  1'b1, FT_FREQ,       7'd8},
    '{64'h0C00_3002_0000_0000, 4'd4, 7'd8,  1'b1, FT_LIMITS,     7'd12},
    '{64'h0500_2800_0100_0000, 4'd5, 7'd0,  1'b1, FT_MODULATION, 7'd5},
    '{64'h0500_2A00_0000_0000, 4'd5, 7'd0,  1'b1, FT_MODE,       7'd5},
    '{64'h0600_3801_0000_0000, 4'd4, 7'd2,  1'b1, FT_POWER,      7'd6},
    '{64'h0500_8000_FF00_0000, 4'd5, 7'd0,  1'b1, FT_SQUELCH,    7'd5},
    '{64'h0000_0720_9000_0000, 4'd6, 7'd3,  1'b1, FT_NONE,       7'd0},   // zero length
    '{64'h01E0_0720_9000_0000, 4'd6, 7'd3,  1'b1, FT_NONE,       7'd0},   // length one
    '{64'h0200_0720_9000_0000, 4'd6, 7'd3,  1'b1, FT_NONE,       7'd0},   // length two
    '{64'h0500_9900_0000_0000, 4'd5, 7'd0,  1'b1, FT_NONE,       7'd0},   // no prefix fits
    '{64'h0720_9000_0000_0000, 4'd4, 7'd3,  1'b0, FT_NONE,       7'd0},
    '{64'h0300_0200_0000_0000, 4'd3, 7'd0,  1'b0, FT_NONE,       7'd0},   // serial cut short
    '{64'h0720_9000_0000_0000, 4'd4, 7'd3,  1'b0, FT_NONE,       7'd0},
    '{64'h3300_0200_0720_9000, 4'd8, 7'd3,  1'b1, FT_NONE,       7'd0},   // one over the limit
    '{64'hFFFF_0720_9000_0000, 4'd6, 7'd3,  1'b1, FT_NONE,       7'd0}    // largest length
  };

  // Random phases: sender idle and receiver stall percentages, and the limit for phases 0 to 2
  localparam int         SEND_IDLE_PCT  [4] = '{0, 84, 0, 17};
  localparam int         RECV_STALL_PCT [4] = '{0, 0, 84, 17};
  localparam logic [6:0] PHASE_LIMIT    [4] = '{7'd64, 7'd4, 7'd47, 7'd0};

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [6:0] cfg_wdata  = '0;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic [4:0] out_frame_type;
  logic [6:0] out_frame_length;
  logic [5:0] out_byte_index;
  logic [7:0] out_byte_value;
  logic       out_last_byte;

  // Predictor state, mirroring the receiver
  state_t     rx_ph = ST_HDR0;
  logic [6:0] bcount = '0;
  logic [6:0] dlen = '0;
  logic [7:0] fstore [STORE_DEPTH];
  logic [0:6][7:0] hunt_win = '0;
  logic [6:0] len_limit = LIMIT_RESET;

  replay_t replay_q [$];     // replayed bytes still owed by the block
  int      pred_results = 0;
  ft_t     last_ft = FT_NONE;
  int      bad_results = 0;
  int      items_sent = 0;
  int      send_idle = 0;
  int      recv_stall = 0;

  length_framed_rx_classifier_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length),
    .out_byte_index   (out_byte_index),
    .out_byte_value   (out_byte_value),
    .out_last_byte    (out_last_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic string show(input replay_t r);
    return $sformatf("type %0d len %0d idx %0d byte %02h last %0b",
                     r.ftype, r.flen, r.idx, r.val, r.last);
  endfunction

  task automatic note_mismatch(input string msg);
    bad_results++;
    if (bad_results <= 10) $display("MISMATCH %s", msg);
  endtask

  // Hunting: the window starts from zeros, so stale bytes cannot fake the signature
  task automatic start_hunt();
    hunt_win = '0;
    bcount   = '0;
    rx_ph    = ST_HUNT;
  endtask

  // Frame complete: first matching prefix wins, positions at or past the length never
  // match; a miss sends the receiver hunting, a hit queues one result per frame byte
  task automatic close_frame();
    ft_t     ft;
    logic    hit;
    replay_t r;
    ft = FT_NONE;
    for (int t = 0; t < int'(FT_NONE) && ft == FT_NONE; t++) begin
      hit = 1'b1;
      for (int k = 0; k < 5; k++) begin
        if (PFX_MASK[t][k] && (k >= int'(dlen) || fstore[k] != PFX_BYTES[t][k])) hit = 1'b0;
      end
      if (hit) ft = ft_t'(t);
    end
    if (ft == FT_NONE) begin
      start_hunt();
      return;
    end
    for (int i = 0; i < int'(dlen); i++) begin
      r.ftype = ft;
      r.flen  = dlen;
      r.idx   = 6'(i);
      r.val   = fstore[i];
      r.last  = (i + 1 == int'(dlen));
      replay_q.push_back(r);
    end
    pred_results += int'(dlen);
    last_ft = ft;
    bcount  = '0;
    rx_ph   = ST_HDR0;
  endtask

  // Predictor step for one accepted byte transaction
  task automatic take_rx_byte(input logic [7:0] b);
    int         flen;
    logic [6:0] eff;
    eff = (len_limit > 7'd64) ? 7'd64 : len_limit;
    case (rx_ph)
      ST_HDR0: begin
        fstore[0] = b;
        bcount    = 7'd1;
        rx_ph     = ST_HDR1;
      end
      ST_HDR1: begin
        if (fstore[0] == LOST_B0 && b == LOST_B1) begin
          // status frame whose first byte went missing: rebuild it, length 7
          fstore[0] = REPAIRED_B0;
          fstore[1] = LOST_B0;
          fstore[2] = LOST_B1;
          bcount    = 7'd3;
          flen      = 7;
        end else begin
          fstore[1] = b;
          bcount    = 7'd2;
          flen      = int'(fstore[0]) + int'(b[4:0]) * 256;
        end
        if (flen > int'(eff)) begin
          start_hunt();
        end else begin
          dlen = 7'(flen);
          // lengths 0..2 may already be complete
          if (bcount >= dlen) close_frame();
          else rx_ph = ST_BODY;
        end
      end
      ST_BODY: begin
        if (bcount < 7'(STORE_DEPTH)) fstore[bcount] = b;
        bcount = bcount + 7'd1;
        if (bcount >= dlen) close_frame();
      end
      default: begin
        // slide the window; leave hunting once the signature heads it
        hunt_win = {hunt_win[1:6], b};
        if (hunt_win[0:3] == STATUS_SIG) begin
          bcount = '0;
          rx_ph  = ST_HDR0;
        end
      end
    endcase
  endtask

  // Drive one byte from the falling edge, idling at random, until the transaction
  // is taken at a rising edge; the predictor follows at that edge
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    take_rx_byte(b);
    items_sent++;
  endtask

  // Hold the sender off until every owed result has come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replay_q.size() != 0) @(posedge clk);
  endtask

  // Limit writes only with the block idle; a frame that classifies to nothing can
  // still be walking the prefix table, hence the extra wait
  task automatic set_length_limit(input logic [6:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_limit = v;
  endtask

  // One random burst, shaped by where the predictor says the receiver stands
  task automatic send_random_sequence();
    int         t;
    int         flen;
    int         n;
    int         eff;
    int         pick;
    logic [7:0] hdr0;
    logic [7:0] b;
    eff = (len_limit > 7'd64) ? 64 : int'(len_limit);
    if (rx_ph == ST_HUNT) begin
      if ($urandom_range(0, 3) == 0) begin
        send_byte(8'($urandom));
      end else begin
        for (int k = 0; k < 4; k++) send_byte(STATUS_SIG[k]);
        repeat (3) send_byte(8'($urandom));
      end
    end else if (rx_ph != ST_HDR0) begin
      send_byte(8'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // status frame with its first byte lost
        send_byte(LOST_B0);
        send_byte(LOST_B1);
        send_byte(($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom));
        repeat (3) send_byte(8'($urandom));
      end else if (pick < 18) begin
        repeat ($urandom_range(2, 6)) send_byte(8'($urandom));
      end else begin
        // well-formed frame of a random type; length follows from its header bytes
        t = $urandom_range(0, int'(FT_NONE) - 1);
        if (ft_t'(t) == FT_SERIAL) begin
          if ($urandom_range(0, 7) == 0) flen = $urandom_range(4, eff);
          else flen = $urandom_range(4, (eff < 10) ? eff : 10);
          hdr0 = 8'(flen);
        end else begin
          hdr0 = PFX_BYTES[t][0];
          flen = int'(hdr0) + int'(PFX_BYTES[t][1][4:0]) * 256;
        end
        n = (flen > eff) ? 2 : flen;
        for (int i = 0; i < n; i++) begin
          if (i == 0) b = hdr0;
          else if (i < 5 && PFX_MASK[t][i]) b = PFX_BYTES[t][i];
          else b = 8'($urandom);
          send_byte(b);
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end
  endtask

  // Receiver: stall decided afresh at every falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Result check: every accepted result against the oldest owed byte
  always @(posedge clk) begin : replay_check
    replay_t got;
    replay_t want;
    if (rst_n && out_valid && out_ready) begin
      got.ftype = ft_t'(out_frame_type);
      got.flen  = out_frame_length;
      got.idx   = out_byte_index;
      got.val   = out_byte_value;
      got.last  = out_last_byte;
      if (replay_q.size() == 0) begin
        note_mismatch({"unexpected result: ", show(got)});
      end else begin
        want = replay_q.pop_front();
        if (got.ftype !== want.ftype || got.flen !== want.flen || got.idx !== want.idx ||
            got.val !== want.val || got.last !== want.last) begin
          note_mismatch($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : run
    int base;
    int phase_end;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset limit, light idling on both sides
    set_length_limit(LIMIT_RESET);
    send_idle  = 17;
    recv_stall = 17;
    for (int r = 0; r < N_DIR; r++) begin
      base = pred_results;
      for (int j = 0; j < int'(DIR_TAB[r].n_lead); j++) send_byte(DIR_TAB[r].lead[j]);
      repeat (DIR_TAB[r].n_fill) send_byte(8'($urandom));
      if (DIR_TAB[r].has_exp &&
          (pred_results - base != int'(DIR_TAB[r].exp_results) ||
           (DIR_TAB[r].exp_results != 0 && last_ft != DIR_TAB[r].exp_type))) begin
        note_mismatch($sformatf("row %0d: table says %0d of %s, predicted %0d of %s", r,
                                DIR_TAB[r].exp_results, DIR_TAB[r].exp_type.name(),
                                pred_results - base, last_ft.name()));
      end
    end

    // random phases, each with its own limit and handshake pressure
    for (int p = 0; p < 4; p++) begin
      set_length_limit((p == 3) ? 7'($urandom_range(4, 64)) : PHASE_LIMIT[p]);
      send_idle  = SEND_IDLE_PCT[p];
      recv_stall = RECV_STALL_PCT[p];
      phase_end  = items_sent + RAND_PER_PHASE;
      while (items_sent < phase_end) send_random_sequence();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_results == 0 && replay_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
